### rtl/core/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg: shared types and constants of the point-in-convex-face test
// Holds the command struct of the shared multiply-accumulate unit and the
// fixed sizes of the vertex store.
// ----------------------------------------------------------------------------
`default_nettype none

package pcf_pkg;

  // Number of vertex slots kept for one face and the address width into them.
  localparam int VERT_SLOTS = 4;
  localparam int SLOT_AW    = $clog2(VERT_SLOTS);

  // Vertex counter saturates at this value.
  localparam logic [2:0] COUNT_MAX = 3'd7;

  // Vertex counts that make a valid face.
  localparam logic [2:0] FACE_TRI  = 3'd3;
  localparam logic [2:0] FACE_QUAD = 3'd4;

  // Command to the multiply-accumulate unit.
  typedef struct packed {
    logic start;     // load operands and begin a product
    logic clear;     // zero the accumulator before this product
    logic sub;       // subtract the product instead of adding it
    logic half_len;  // multiplier operand fits in a coordinate difference
  } mac_cmd_t;

endpackage

`default_nettype wire

### rtl/core/pcf_ram.sv
// ----------------------------------------------------------------------------
// pcf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/pcf_mac.sv
// ----------------------------------------------------------------------------
// pcf_mac: bit-serial signed multiply-accumulate unit
// Adds or subtracts the product of two signed operands into a wide
// accumulator, one multiplier bit per cycle, with the top bit weighted
// negative as in two's complement.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_mac #(
  parameter int OW = 35,
  parameter int SW = 17,
  parameter int AW = 72
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire pcf_pkg::mac_cmd_t      cmd,
  input  wire logic signed [OW-1:0]   op_a,
  input  wire logic signed [OW-1:0]   op_b,
  output logic                        done,
  output logic signed [AW-1:0]        acc
);

  import pcf_pkg::*;

  localparam int CW = $clog2(OW + 1);
  localparam logic [CW-1:0] LEN_FULL = CW'(OW);
  localparam logic [CW-1:0] LEN_HALF = CW'(SW);

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic signed [AW-1:0] mcand;
  logic [OW-1:0]        mplier;
  logic                 sub;
  logic                 last_bit;

  assign last_bit = (cnt == CW'(1));

  // Control: busy while bits remain, done pulses after the last bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && last_bit) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: shift-add step, the sign bit of the multiplier subtracts.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cnt    <= cmd.half_len ? LEN_HALF : LEN_FULL;
      mcand  <= {{(AW - OW){op_a[OW-1]}}, op_a};
      mplier <= op_b;
      sub    <= cmd.sub;
      if (cmd.clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (mplier[0]) begin
        if (sub ^ last_bit) begin
          acc <= acc - mcand;
        end else begin
          acc <= acc + mcand;
        end
      end
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
      cnt    <= cnt - CW'(1);
    end
  end

endmodule

`default_nettype wire

### rtl/core/point_in_convex_face_test_core.sv
// ----------------------------------------------------------------------------
// point_in_convex_face_test_core: point-in-convex-face test
// Tests whether a query point projects inside a triangle or quad face.
// ----------------------------------------------------------------------------
// Usage: the item channel (item_valid / item_ready) takes one beat per query
// point (item_kind 0) or face vertex (item_kind 1, counterclockwise order).
// A query point starts a new face. The vertex beat with last_vertex set ends
// the face and yields one beat on the result channel (res_valid / res_ready)
// carrying inside_res and bad_face. All other beats yield no result.
// A face of the wrong size goes from its last beat through the finish state
// to the result register with bad_face set. A good face runs on one shared
// bit-serial multiply-accumulate unit: six products of coordinate-difference
// width for the normal, then per edge six such products and three of double
// width. Edges are tested in turn, stopping at the first failing edge.
// item_ready is low while a face is evaluated. The result sits in an output
// register; a stalled receiver holds it, and the block keeps taking beats
// until a second result would be due. Synchronous reset clears the query
// point to zero, the vertex count, and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_convex_face_test_core #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_ready,
  input  wire logic                         item_kind,
  input  wire logic signed [COORD_BITS-1:0] coord_x,
  input  wire logic signed [COORD_BITS-1:0] coord_y,
  input  wire logic signed [COORD_BITS-1:0] coord_z,
  input  wire logic                         last_vertex,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output logic                              inside_res,
  output logic                              bad_face
);

  import pcf_pkg::*;

  localparam int VW = 3 * COORD_BITS;      // packed vertex {z, y, x}
  localparam int DW = COORD_BITS + 1;      // coordinate difference
  localparam int NW = 2 * COORD_BITS + 3;  // normal and edge cross terms
  localparam int AW = 4 * COORD_BITS + 8;  // dot product accumulator

  localparam logic KIND_QUERY = 1'b0;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOAD  = 7'b0000010,
    ST_CROSS = 7'b0000100,
    ST_DOT   = 7'b0001000,
    ST_NEXT  = 7'b0010000,
    ST_FETCH = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  state_t state;

  logic                  accept;
  logic [VW-1:0]         qp;
  logic [2:0]            vcount;
  logic [2:0]            cnt_sat;
  logic [2:0]            nv;
  logic [1:0]            ld;
  logic [SLOT_AW-1:0]    k;
  logic [2:0]            k_inc;
  logic [2:0]            k_inc2;
  logic [SLOT_AW-1:0]    nidx;
  logic [VW-1:0]         cur;
  logic [VW-1:0]         nxt;
  logic [VW-1:0]         tmp;
  logic                  is_norm;
  logic [2:0]            opi;
  logic                  issued;
  logic                  res_inside;
  logic                  res_bad;
  logic                  fin_load;

  logic                  ram_we;
  logic [SLOT_AW-1:0]    ram_raddr;
  logic [VW-1:0]         ram_rdata;

  logic signed [DW-1:0]  xd [3];
  logic signed [DW-1:0]  yd [3];
  logic [1:0]            i1;
  logic [1:0]            i2;
  logic signed [DW-1:0]  xa;
  logic signed [DW-1:0]  yb;
  logic signed [NW-1:0]  nrm [3];
  logic signed [NW-1:0]  cr  [3];

  mac_cmd_t              cmd;
  logic signed [NW-1:0]  op_a;
  logic signed [NW-1:0]  op_b;
  logic                  mac_done;
  logic signed [AW-1:0]  acc;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign cnt_sat    = (vcount == COUNT_MAX) ? COUNT_MAX : vcount + 3'd1;
  assign ram_we     = accept && (item_kind != KIND_QUERY) && (vcount < 3'(VERT_SLOTS));
  assign k_inc      = {1'b0, k} + 3'd1;
  assign k_inc2     = k_inc + 3'd1;
  assign nidx       = (k_inc2 == nv) ? '0 : k_inc2[SLOT_AW-1:0];
  assign fin_load   = (state == ST_FIN) && (!res_valid || res_ready);

  // Vertex store.
  pcf_ram #(
    .WIDTH (VW),
    .DEPTH (VERT_SLOTS)
  ) u_vert_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (vcount[SLOT_AW-1:0]),
    .wdata ({coord_z, coord_y, coord_x}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read address: first three vertices while loading, next vertex per edge.
  always_comb begin
    case (state)
      ST_LOAD: ram_raddr = ld[SLOT_AW-1:0];
      ST_NEXT: ram_raddr = nidx;
      default: ram_raddr = '0;
    endcase
  end

  // Coordinate differences: edge vector, and either v2 - v0 or point - cur.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xd[i] = $signed({nxt[i*COORD_BITS + COORD_BITS - 1], nxt[i*COORD_BITS +: COORD_BITS]})
            - $signed({cur[i*COORD_BITS + COORD_BITS - 1], cur[i*COORD_BITS +: COORD_BITS]});
      if (is_norm) begin
        yd[i] = $signed({tmp[i*COORD_BITS + COORD_BITS - 1], tmp[i*COORD_BITS +: COORD_BITS]})
              - $signed({cur[i*COORD_BITS + COORD_BITS - 1], cur[i*COORD_BITS +: COORD_BITS]});
      end else begin
        yd[i] = $signed({qp[i*COORD_BITS + COORD_BITS - 1], qp[i*COORD_BITS +: COORD_BITS]})
              - $signed({cur[i*COORD_BITS + COORD_BITS - 1], cur[i*COORD_BITS +: COORD_BITS]});
      end
    end
  end

  // Component pair of the cross product term being formed.
  always_comb begin
    case (opi[2:1])
      2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
      2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
      default: begin i1 = 2'd0; i2 = 2'd1; end
    endcase
    xa = opi[0] ? xd[i2] : xd[i1];
    yb = opi[0] ? yd[i1] : yd[i2];
  end

  // Operands and command for the shared multiply-accumulate unit.
  always_comb begin
    cmd       = '0;
    cmd.start = ((state == ST_CROSS) || (state == ST_DOT)) && !issued;
    if (state == ST_DOT) begin
      op_a      = cr[opi[1:0]];
      op_b      = nrm[opi[1:0]];
      cmd.clear = (opi == 3'd0);
    end else begin
      op_a         = {{(NW - DW){xa[DW-1]}}, xa};
      op_b         = {{(NW - DW){yb[DW-1]}}, yb};
      cmd.clear    = !opi[0];
      cmd.sub      = opi[0];
      cmd.half_len = 1'b1;
    end
  end

  pcf_mac #(
    .OW (NW),
    .SW (DW),
    .AW (AW)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .op_a (op_a),
    .op_b (op_b),
    .done (mac_done),
    .acc  (acc)
  );

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      qp     <= '0;
      vcount <= '0;
      issued <= 1'b0;
    end else begin
      if (cmd.start) begin
        issued <= 1'b1;
      end else if (mac_done) begin
        issued <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (item_kind == KIND_QUERY) begin
              qp     <= {coord_z, coord_y, coord_x};
              vcount <= '0;
            end else if (last_vertex) begin
              vcount <= '0;
              if ((cnt_sat == FACE_TRI) || (cnt_sat == FACE_QUAD)) begin
                state <= ST_LOAD;
              end else begin
                state <= ST_FIN;
              end
            end else begin
              vcount <= cnt_sat;
            end
          end
        end
        ST_LOAD: begin
          if (ld == 2'd3) begin
            state <= ST_CROSS;
          end
        end
        ST_CROSS: begin
          if (mac_done && (opi == 3'd5) && !is_norm) begin
            state <= ST_DOT;
          end
        end
        ST_DOT: begin
          if (mac_done && (opi == 3'd2)) begin
            state <= acc[AW-1] ? ST_FIN : ST_NEXT;
          end
        end
        ST_NEXT: begin
          state <= (k_inc == nv) ? ST_FIN : ST_FETCH;
        end
        ST_FETCH: begin
          state <= ST_CROSS;
        end
        ST_FIN: begin
          if (fin_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Working registers of the face evaluation.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        ld      <= 2'd0;
        k       <= '0;
        opi     <= 3'd0;
        is_norm <= 1'b1;
        if (accept && (item_kind != KIND_QUERY) && last_vertex) begin
          nv         <= cnt_sat;
          res_inside <= 1'b0;
          res_bad    <= 1'b1;
        end
      end
      ST_LOAD: begin
        ld <= ld + 2'd1;
        case (ld)
          2'd1:    cur <= ram_rdata;
          2'd2:    nxt <= ram_rdata;
          2'd3:    tmp <= ram_rdata;
          default: ;
        endcase
      end
      ST_CROSS: begin
        if (mac_done) begin
          if (opi[0]) begin
            if (is_norm) begin
              nrm[opi[2:1]] <= acc[NW-1:0];
            end else begin
              cr[opi[2:1]] <= acc[NW-1:0];
            end
          end
          if (opi == 3'd5) begin
            opi     <= 3'd0;
            is_norm <= 1'b0;
          end else begin
            opi <= opi + 3'd1;
          end
        end
      end
      ST_DOT: begin
        if (mac_done) begin
          if (opi == 3'd2) begin
            opi        <= 3'd0;
            res_inside <= 1'b0;
            res_bad    <= 1'b0;
          end else begin
            opi <= opi + 3'd1;
          end
        end
      end
      ST_NEXT: begin
        if (k_inc == nv) begin
          res_inside <= 1'b1;
          res_bad    <= 1'b0;
        end else begin
          cur <= nxt;
          k   <= k_inc[SLOT_AW-1:0];
        end
      end
      ST_FETCH: begin
        nxt <= ram_rdata;
      end
      default: ;
    endcase
  end

  // Result output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fin_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      inside_res <= res_inside;
      bad_face   <= res_bad;
    end
  end

endmodule

`default_nettype wire

### tb/point_in_convex_face_test_core_checker.sv
// ----------------------------------------------------------------------------
// point_in_convex_face_test_core_checker: result checker for the face test
// Watches the item and result channels of the point-in-convex-face core,
// keeps its own copy of the query point, vertex slots and vertex count, and
// works out the verdict of every face from exact wide integer arithmetic.
// Each result beat is compared field by field with the oldest open verdict.
// ----------------------------------------------------------------------------

package pcf_tb_pkg;

  // Meaning of the item_kind bit.
  localparam logic KIND_POINT  = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  // One expected result beat.
  typedef struct packed {
    logic in_face;
    logic bad;
  } face_verdict_t;

endpackage

module point_in_convex_face_test_core_checker
  import pcf_pkg::*;
  import pcf_tb_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  logic                         item_ready,
  input  logic                         item_kind,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  input  logic                         last_vertex,
  input  logic                         res_valid,
  input  logic                         res_ready,
  input  logic                         inside_res,
  input  logic                         bad_face,
  output int                           fail_count,
  output int                           outstanding
);

  // Products of normal and edge terms stay well under 128 bits.
  typedef logic signed [127:0] wide_t;
  typedef struct packed {
    wide_t x;
    wide_t y;
    wide_t z;
  } vec_t;

  vec_t          query_pt;
  vec_t          corners [VERT_SLOTS];
  logic [2:0]    corner_cnt;
  face_verdict_t face_verdicts_q [$];
  int            errors = 0;
  int            open_verdicts = 0;

  assign fail_count  = errors;
  assign outstanding = open_verdicts;

  function automatic vec_t vsub(vec_t a, vec_t b);
    vec_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic vec_t vcross(vec_t a, vec_t b);
    vec_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  function automatic wide_t vdot(vec_t a, vec_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  // The projection is inside when no edge term is negative. The normal comes
  // from the first three vertices, so a zero normal makes every term zero.
  function automatic logic projects_inside(logic [2:0] nv);
    vec_t  nrm;
    vec_t  edge_v;
    vec_t  to_pt;
    int    nxt;
    logic  ok;
    nrm = vcross(vsub(corners[1], corners[0]), vsub(corners[2], corners[0]));
    ok  = 1'b1;
    for (int k = 0; k < nv; k++) begin
      nxt    = (k + 1 == nv) ? 0 : k + 1;
      edge_v = vsub(corners[SLOT_AW'(nxt)], corners[SLOT_AW'(k)]);
      to_pt  = vsub(query_pt, corners[SLOT_AW'(k)]);
      if (vdot(vcross(edge_v, to_pt), nrm) < 0) ok = 1'b0;
    end
    return ok;
  endfunction

  // Apply one accepted item beat to the shadow state.
  function automatic void take_beat();
    vec_t          c;
    logic [2:0]    nv;
    face_verdict_t v;
    c.x = coord_x;
    c.y = coord_y;
    c.z = coord_z;
    if (item_kind == KIND_POINT) begin
      // A query point starts a new face; its last mark means nothing.
      query_pt   = c;
      corner_cnt = '0;
    end else begin
      // Vertices past the slot count are dropped but still counted.
      if (corner_cnt < VERT_SLOTS) corners[corner_cnt[SLOT_AW-1:0]] = c;
      if (corner_cnt < COUNT_MAX) corner_cnt = corner_cnt + 3'd1;
      if (last_vertex) begin
        nv         = corner_cnt;
        corner_cnt = '0;
        if (nv != FACE_TRI && nv != FACE_QUAD) begin
          v.in_face = 1'b0;
          v.bad     = 1'b1;
        end else begin
          v.in_face = projects_inside(nv);
          v.bad     = 1'b0;
        end
        face_verdicts_q.push_back(v);
      end
    end
  endfunction

  // Compare result beats first: a result can never belong to a vertex that
  // is accepted at the same edge.
  always @(posedge clk) begin
    face_verdict_t want;
    if (rst) begin
      query_pt   = '0;
      corner_cnt = '0;
      face_verdicts_q.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (face_verdicts_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with no open verdict: inside_res=%0b bad_face=%0b",
                   $time, inside_res, bad_face);
        end else begin
          want = face_verdicts_q.pop_front();
          if (inside_res !== want.in_face) begin
            errors++;
            $display("%0t: inside_res mismatch: expected %0b, actual %0b",
                     $time, want.in_face, inside_res);
          end
          if (bad_face !== want.bad) begin
            errors++;
            $display("%0t: bad_face mismatch: expected %0b, actual %0b",
                     $time, want.bad, bad_face);
          end
        end
      end
      if (item_valid && item_ready) take_beat();
    end
    open_verdicts = face_verdicts_q.size();
  end

endmodule

### tb/point_in_convex_face_test_core_test.sv
// ----------------------------------------------------------------------------
// point_in_convex_face_test_core_test: testbench top of the face test core
// Drives query points and face vertices into the core, first a short list of
// corner cases, then random good, wrong-size and broken faces and stray points,
// with random gaps on the item side and random stalls on the result side. A checker
// beside the core predicts and compares every result beat.
// ----------------------------------------------------------------------------

module point_in_convex_face_test_core_test;
  import pcf_tb_pkg::*;

  localparam int CB           = 16;
  localparam int RANDOM_BEATS = 850;
  localparam int DRAIN_CYCLES = 1200;
  localparam int HOLD_CYCLES  = 6000;
  // Room for a full face evaluation, sender gaps and receiver stalls for
  // every beat as a final vertex, then taken several times over.
  localparam longint CYCLE_LIMIT = 6_000_000;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 item_valid  = 1'b0;
  logic                 item_kind   = KIND_POINT;
  logic signed [CB-1:0] coord_x     = '0;
  logic signed [CB-1:0] coord_y     = '0;
  logic signed [CB-1:0] coord_z     = '0;
  logic                 last_vertex = 1'b0;
  logic                 res_ready   = 1'b0;
  logic                 item_ready;
  logic                 res_valid;
  logic                 inside_res;
  logic                 bad_face;
  int                   fail_count;
  int                   outstanding;
  int                   beats_sent  = 0;
  bit                   quiet       = 1'b0;
  bit                   hold_req    = 1'b0;
  longint               cycles      = 0;

  always #4 clk = ~clk;

  point_in_convex_face_test_core #(
    .COORD_BITS(CB)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_kind  (item_kind),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .last_vertex(last_vertex),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .inside_res (inside_res),
    .bad_face   (bad_face)
  );

  point_in_convex_face_test_core_checker #(
    .COORD_BITS(CB)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_kind  (item_kind),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .last_vertex(last_vertex),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .inside_res (inside_res),
    .bad_face   (bad_face),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("point_in_convex_face_test_core_test: FAIL");
      $finish;
    end
  end

  // Idle gap before a beat: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Signed value in [-s, s]; s of zero means any 16-bit pattern.
  function automatic int rand_coord(int s);
    if (s == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 2 * s)) - s;
  endfunction

  // Offer one item beat at a falling edge and hold it until accepted.
  task automatic send_beat(logic kind, int x, int y, int z, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_kind   = kind;
    coord_x     = x[CB-1:0];
    coord_y     = y[CB-1:0];
    coord_z     = z[CB-1:0];
    last_vertex = last;
    item_valid  = 1'b1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
    beats_sent++;
  endtask

  // Well-formed face: a planar triangle or parallelogram, or random corners,
  // with the query point near the centroid, on a vertex or edge, or anywhere.
  task automatic run_face();
    int nv, s, pick, k, nk;
    int vx [4];
    int vy [4];
    int vz [4];
    int ox, oy, oz, ux, uy, uz, wx, wy, wz, px, py, pz;
    nv = $urandom_range(3, 4);
    pick = $urandom_range(0, 2);
    s = (pick == 0) ? 8 : (pick == 1) ? 1000 : 16000;
    if ($urandom_range(0, 9) < 2) begin
      s = 0;
      for (k = 0; k < 4; k++) begin
        vx[2'(k)] = rand_coord(0);
        vy[2'(k)] = rand_coord(0);
        vz[2'(k)] = rand_coord(0);
      end
    end else begin
      ox = rand_coord(s);      oy = rand_coord(s);      oz = rand_coord(s);
      ux = rand_coord(s / 2);  uy = rand_coord(s / 2);  uz = rand_coord(s / 2);
      wx = rand_coord(s / 2);  wy = rand_coord(s / 2);  wz = rand_coord(s / 2);
      vx[0] = ox;      vy[0] = oy;      vz[0] = oz;
      vx[1] = ox + ux; vy[1] = oy + uy; vz[1] = oz + uz;
      if (nv == 3) begin
        vx[2] = ox + wx;      vy[2] = oy + wy;      vz[2] = oz + wz;
      end else begin
        vx[2] = ox + ux + wx; vy[2] = oy + uy + wy; vz[2] = oz + uz + wz;
        vx[3] = ox + wx;      vy[3] = oy + wy;      vz[3] = oz + wz;
      end
      // Now and then bend one corner out of the plane.
      if ($urandom_range(0, 9) == 0) vz[2'($urandom_range(0, nv - 1))] += rand_coord(s / 4 + 1);
    end

    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      px = 0; py = 0; pz = 0;
      for (k = 0; k < nv; k++) begin
        px += vx[2'(k)]; py += vy[2'(k)]; pz += vz[2'(k)];
      end
      px = px / nv + rand_coord(1);
      py = py / nv + rand_coord(1);
      pz = pz / nv + rand_coord(1);
      if ($urandom_range(0, 1) == 1) pz += rand_coord(s / 4);
    end else if (pick < 7) begin
      k  = $urandom_range(0, nv - 1);
      nk = (k + 1) % nv;
      if ($urandom_range(0, 1) == 1) begin
        px = vx[2'(k)]; py = vy[2'(k)]; pz = vz[2'(k)];
      end else begin
        px = (vx[2'(k)] + vx[2'(nk)]) / 2;
        py = (vy[2'(k)] + vy[2'(nk)]) / 2;
        pz = (vz[2'(k)] + vz[2'(nk)]) / 2;
      end
    end else begin
      px = rand_coord(s); py = rand_coord(s); pz = rand_coord(s);
    end

    // Leaving out the query point reuses the previous one.
    if ($urandom_range(0, 9) != 0)
      send_beat(KIND_POINT, px, py, pz, 1'($urandom_range(0, 1)));
    for (k = 0; k < nv; k++)
      send_beat(KIND_VERTEX, vx[2'(k)], vy[2'(k)], vz[2'(k)], k == nv - 1);
  endtask

  // Face with a vertex count other than three or four.
  task automatic run_bad_face();
    int nv, s, k;
    case ($urandom_range(0, 6))
      0: nv = 1;
      1: nv = 2;
      2: nv = 5;
      3: nv = 6;
      4: nv = 7;
      5: nv = 8;
      default: nv = 9;
    endcase
    s = ($urandom_range(0, 1) == 1) ? 0 : 8;
    if ($urandom_range(0, 1) == 1)
      send_beat(KIND_POINT, rand_coord(s), rand_coord(s), rand_coord(s),
                1'($urandom_range(0, 1)));
    for (k = 0; k < nv; k++)
      send_beat(KIND_VERTEX, rand_coord(s), rand_coord(s), rand_coord(s), k == nv - 1);
  endtask

  // Face cut short by whatever comes next.
  task automatic run_broken_face();
    int nv, k;
    nv = $urandom_range(1, 3);
    send_beat(KIND_POINT, rand_coord(0), rand_coord(0), rand_coord(0), 1'b0);
    for (k = 0; k < nv; k++)
      send_beat(KIND_VERTEX, rand_coord(0), rand_coord(0), rand_coord(0), 1'b0);
  endtask

  // Result side: random stalls, quiet stretches, and one long hold-off on
  // request so that the core fills up and stops taking beats.
  initial begin : receiver
    int stall_left;
    int r;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        res_ready = 1'b0;
        stall_left--;
      end else if (quiet) begin
        res_ready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          res_ready = 1'b1;
        end else if (r < 94) begin
          res_ready  = 1'b0;
          stall_left = $urandom_range(0, 3);
        end else begin
          res_ready  = 1'b0;
          stall_left = $urandom_range(20, 150);
        end
      end
    end
  end

  // Item side and verdict.
  initial begin : stimulus
    int seq_n;
    int r;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Triangle around the origin, checked against the query point after reset.
    send_beat(KIND_VERTEX, -4, -4, 0, 1'b0);
    send_beat(KIND_VERTEX, 4, -4, 0, 1'b0);
    send_beat(KIND_VERTEX, 0, 4, 0, 1'b1);
    // Query point at the extremes, with a last mark that must be ignored.
    send_beat(KIND_POINT, 32767, 32767, -32768, 1'b1);
    // Quad spanning the full coordinate range.
    send_beat(KIND_VERTEX, -32768, -32768, 32767, 1'b0);
    send_beat(KIND_VERTEX, 32767, -32768, 32767, 1'b0);
    send_beat(KIND_VERTEX, 32767, 32767, -32768, 1'b0);
    send_beat(KIND_VERTEX, -32768, 32767, -32768, 1'b1);
    // Degenerate face with a zero normal.
    send_beat(KIND_POINT, -1, -1, -1, 1'b0);
    send_beat(KIND_VERTEX, 5, 5, 5, 1'b0);
    send_beat(KIND_VERTEX, 5, 5, 5, 1'b0);
    send_beat(KIND_VERTEX, 5, 5, 5, 1'b1);
    // Query point lying on an edge, off the plane.
    send_beat(KIND_POINT, 0, -4, 7, 1'b0);
    send_beat(KIND_VERTEX, -4, -4, 0, 1'b0);
    send_beat(KIND_VERTEX, 4, -4, 0, 1'b0);
    send_beat(KIND_VERTEX, 0, 4, 0, 1'b1);
    // Two vertices only.
    send_beat(KIND_VERTEX, 1, 2, 3, 1'b0);
    send_beat(KIND_VERTEX, -3, -2, -1, 1'b1);
    // Five vertices: the fifth is not stored.
    send_beat(KIND_VERTEX, 0, 0, 0, 1'b0);
    send_beat(KIND_VERTEX, 10, 0, 0, 1'b0);
    send_beat(KIND_VERTEX, 10, 10, 0, 1'b0);
    send_beat(KIND_VERTEX, 0, 10, 0, 1'b0);
    send_beat(KIND_VERTEX, -5, 5, 0, 1'b1);
    // A single marked vertex.
    send_beat(KIND_VERTEX, 7, 7, 7, 1'b1);

    // Random part, in stretches that switch idling off now and then.
    seq_n = 0;
    while (beats_sent < RANDOM_BEATS + 24) begin
      if (seq_n % 25 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (beats_sent > 400) hold_req = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 75) run_face();
      else if (r < 88) run_bad_face();
      else if (r < 95) run_broken_face();
      else send_beat(KIND_POINT, rand_coord(0), rand_coord(0), rand_coord(0),
                     1'($urandom_range(0, 1)));
      seq_n++;
    end
    item_valid = 1'b0;
    quiet      = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("point_in_convex_face_test_core_test: PASS");
    end else begin
      $display("point_in_convex_face_test_core_test: FAIL");
    end
    $finish;
  end

endmodule
